/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is high
`define BPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked property that also holds during reset
`define BPA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BPA_ASSERT(lbl, clk, rst, prop, msg)
`define BPA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

  // Fixed word field widths
  localparam int CMD_W    = 2;
  localparam int PAGE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 17;

  // Default sizing
  localparam int DEF_MAX_PAGES = 65536;
  localparam int DEF_WORD_BITS = 32;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_TOTAL_PAGES = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_INVALID = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_NULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_PAGE,
    S_RESP
  } state_t;

endpackage

/* rtl/core/bitmap_page_allocator_unit.sv */
// Bitmap page allocator top level: bitmap memory, sequencer and output register.
// Free or reserve: decode, bitmap update, result; a word rejected at decode goes straight to the result.
// Allocate: decode, then a scan from the low-water word hint that skips full words, then the result;
// straight to the result when the hint already lies past the total. One word at a time: the next
// is accepted only once the result is loaded and the sequencer is back in idle.
// Reset and each page total write run a clearing pass over all NUM_WORDS (2048) words; no word meanwhile.
module bitmap_page_allocator_unit #(
  parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
  parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]   paddr,
  input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
  output logic [bpa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpa_pkg::CMD_W-1:0]    command,
  input  logic [bpa_pkg::PAGE_W-1:0]   page,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpa_pkg::PAGE_W-1:0]   page_out,
  output logic [bpa_pkg::STATUS_W-1:0] status,
  output logic [bpa_pkg::CFG_W-1:0]    free_pages
);
  import bpa_pkg::*;
  `include "assert_macros.svh"

  localparam int WB        = WORD_BITS;
  localparam int NUM_WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WB);
  localparam int HW        = $clog2(NUM_WORDS + 1);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int CW        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int XW        = (HW + BW > CW) ? (HW + BW) : CW;

  // Lowest clear bit of a bitmap word: isolate it, then encode the one-hot
  function automatic logic [BW-1:0] low_zero(input logic [WB-1:0] w);
    logic [WB-1:0] inv;
    logic [WB-1:0] iso;
    logic [BW-1:0] idx;
    inv = ~w;
    iso = inv & (~inv + WB'(1));
    idx = '0;
    for (int k = 0; k < BW; k++) begin
      for (int j = 0; j < WB; j++) begin
        if (j[k]) begin
          idx[k] = idx[k] | iso[j];
        end
      end
    end
    return idx;
  endfunction

  // True once the scan has run past the bitmap or past the page total
  function automatic logic scan_end(input logic [HW-1:0] h, input logic [CNT_W-1:0] tot);
    return (XW'(h) >= XW'(NUM_WORDS)) || ((XW'(h) << BW) >= XW'(tot));
  endfunction

  // Configuration
  logic [CNT_W-1:0] total;
  logic             total_load;
  logic [CNT_W-1:0] load_value;

  bpa_cfg #(
    .MAX_PAGES (MAX_PAGES),
    .CNT_W     (CNT_W)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .total      (total),
    .total_load (total_load),
    .load_value (load_value)
  );

  // Control and working registers
  state_t           state, state_next;
  logic [HW-1:0]    hint, hint_next;
  logic [CNT_W-1:0] used, used_next;
  logic [AW-1:0]    clr_addr, clr_next;
  logic [CMD_W-1:0] cmd_q;
  logic [PAGE_W-1:0] pg_q;
  logic [PAGE_W-1:0] res_page, res_page_next;
  status_t          res_status, res_status_next;
  logic             load_out;

  // Bitmap memory
  logic [WB-1:0] mem [NUM_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [WB-1:0] mem_wdata;
  logic [WB-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // Decode of the held word
  logic [XW-1:0] pg_x;
  logic          pg_bad;
  logic [AW-1:0] pw;
  logic [BW-1:0] pb;
  logic [HW-1:0] hint_inc;
  logic [BW-1:0] lz;
  logic [XW-1:0] found;
  logic [CW-1:0] free_w;

  assign pg_x     = XW'(pg_q);
  assign pg_bad   = pg_x >= XW'(total);
  assign pw       = pg_x[BW +: AW];
  assign pb       = pg_x[BW-1:0];
  assign hint_inc = hint + HW'(1);
  assign lz       = low_zero(rd_q);
  assign found    = (XW'(hint) << BW) | XW'(lz);
  assign free_w   = CW'(total) - CW'(used);

  assign in_ready = (state == S_IDLE) && !total_load;

  // Sequencer: next state, memory access and result
  always_comb begin
    state_next      = state;
    hint_next       = hint;
    used_next       = used;
    clr_next        = clr_addr;
    res_page_next   = res_page;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = pw;
    mem_raddr       = pw;
    mem_wdata       = rd_q;
    load_out        = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '1;
        clr_next  = clr_addr + AW'(1);
        if (clr_addr == AW'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_page_next   = pg_q;
        res_status_next = ST_OK;
        case (cmd_q)
          CMD_ALLOC: begin
            mem_raddr = hint[AW-1:0];
            if (scan_end(hint, total)) begin
              res_page_next   = '0;
              res_status_next = ST_OOM;
              state_next      = S_RESP;
            end else begin
              state_next = S_ALLOC;
            end
          end
          CMD_FREE: begin
            if (pg_q == '0) begin
              res_status_next = ST_NULL;
              state_next      = S_RESP;
            end else if (pg_bad) begin
              res_status_next = ST_INVALID;
              state_next      = S_RESP;
            end else begin
              state_next = S_PAGE;
            end
          end
          CMD_RESERVE: begin
            if (pg_bad) begin
              res_status_next = ST_INVALID;
              state_next      = S_RESP;
            end else begin
              state_next = S_PAGE;
            end
          end
          default: begin
            res_status_next = ST_INVALID;
            state_next      = S_RESP;
          end
        endcase
      end
      S_ALLOC: begin
        if (&rd_q) begin
          // full word: move the hint on and read the next one
          hint_next = hint_inc;
          mem_raddr = hint_inc[AW-1:0];
          if (scan_end(hint_inc, total)) begin
            res_page_next   = '0;
            res_status_next = ST_OOM;
            state_next      = S_RESP;
          end
        end else if (found >= XW'(total)) begin
          res_page_next   = '0;
          res_status_next = ST_OOM;
          state_next      = S_RESP;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = hint[AW-1:0];
          mem_wdata     = rd_q | (WB'(1) << lz);
          used_next     = used + CNT_W'(1);
          res_page_next = found[PAGE_W-1:0];
          state_next    = S_RESP;
        end
      end
      S_PAGE: begin
        if (cmd_q == CMD_FREE) begin
          if (!rd_q[pb]) begin
            res_status_next = ST_DOUBLE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_q & ~(WB'(1) << pb);
            if (used != '0) begin
              used_next = used - CNT_W'(1);
            end
            if (HW'(pw) < hint) begin
              hint_next = HW'(pw);
            end
          end
        end else if (!rd_q[pb]) begin
          mem_we    = 1'b1;
          mem_wdata = rd_q | (WB'(1) << pb);
          used_next = used + CNT_W'(1);
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // page total write: every page used again
    if (total_load) begin
      state_next = S_CLEAR;
      clr_next   = '0;
      used_next  = load_value;
      hint_next  = HW'(NUM_WORDS);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      hint     <= HW'(NUM_WORDS);
      used     <= CNT_W'(MAX_PAGES);
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      hint     <= hint_next;
      used     <= used_next;
      clr_addr <= clr_next;
    end
  end

  // Held input word and pending result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= command;
      pg_q  <= page;
    end
    res_page   <= res_page_next;
    res_status <= res_status_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      page_out   <= res_page;
      status     <= res_status;
      free_pages <= free_w[CFG_W-1:0];
    end
  end

  // Checks
  `BPA_ASSERT(a_used_le_total, clk, rst, used <= total, "used count above page total")
  `BPA_ASSERT(a_oom_null_page, clk, rst, (out_valid && status == ST_OOM) |-> (page_out == '0), "out of memory word carries a page")
  `BPA_ASSERT(a_we_states, clk, rst, mem_we |-> (state == S_CLEAR || state == S_ALLOC || state == S_PAGE), "bitmap written outside clear or update")
  `BPA_ASSERT(a_hint_range, clk, rst, hint <= HW'(NUM_WORDS), "word hint beyond bitmap")
  `BPA_ASSERT_RST(a_reset_clear, clk, rst |=> (state == S_CLEAR && !out_valid && !in_ready), "reset does not start the clearing pass")

endmodule

/* rtl/core/bpa_cfg.sv */
// Register port of the allocator: page total register with saturation.
module bpa_cfg #(
  parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
  parameter int CNT_W     = $clog2(bpa_pkg::DEF_MAX_PAGES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpa_pkg::APB_AW-1:0] paddr,
  input  logic [bpa_pkg::APB_DW-1:0] pwdata,
  output logic [bpa_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [CNT_W-1:0]           total,
  output logic                       total_load,
  output logic [CNT_W-1:0]           load_value
);
  import bpa_pkg::*;

  localparam int CW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic            reg_hit;
  logic [CFG_W-1:0] wr_raw;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_TOTAL_PAGES);
  assign wr_raw  = pwdata[CFG_W-1:0];

  // Write strobe and saturated value
  assign total_load = psel && penable && pwrite && pready && reg_hit;
  always_comb begin
    if (CW'(wr_raw) > CW'(MAX_PAGES)) begin
      load_value = CNT_W'(MAX_PAGES);
    end else begin
      load_value = CNT_W'(wr_raw);
    end
  end

  // Page total register
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= CNT_W'(MAX_PAGES);
    end else if (total_load) begin
      total <= load_value;
    end
  end

  // Read back
  always_comb begin
    if (psel && reg_hit) begin
      prdata = APB_DW'(total);
    end else begin
      prdata = '0;
    end
  end

endmodule

/* tb/bitmap_page_allocator_checker.sv */
// Checker for the page allocator: tracks register writes, predicts each result and compares.
`timescale 1ns / 1ps

module bitmap_page_allocator_checker
  import bpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // register port, watched only
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic [APB_DW-1:0]   prdata,
  input  logic                pready,
  // input channel
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [PAGE_W-1:0]   page,
  // output channel
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [PAGE_W-1:0]   page_out,
  input  logic [STATUS_W-1:0] status,
  input  logic [CFG_W-1:0]    free_pages,
  // to the testbench top
  output int                  pending,
  output int                  fail_count
);

  localparam int unsigned MAX_PAGES = DEF_MAX_PAGES;
  localparam int unsigned WORD_BITS = DEF_WORD_BITS;
  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;

  typedef struct {
    logic [PAGE_W-1:0] page_nr;
    status_t           st;
    logic [CFG_W-1:0]  free_cnt;
  } page_result_t;

  // shadow of the allocator state
  logic [WORD_BITS-1:0] page_map [NUM_WORDS];
  int unsigned          pages_in_use;
  int unsigned          page_total;

  page_result_t awaited_results[$];
  int unsigned  result_index;

  // every page marked used, count follows the total
  function automatic void mark_every_page_used();
    for (int w = 0; w < NUM_WORDS; w++) page_map[w] = '1;
    pages_in_use = page_total;
  endfunction

  function automatic bit page_is_used(input int unsigned pnum);
    return page_map[pnum / WORD_BITS][pnum % WORD_BITS];
  endfunction

  // lowest clear bit below the total; full words are skipped
  function automatic bit lowest_free_page(output int unsigned found);
    int unsigned pnum;
    found = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (page_map[w] != '1) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          pnum = w * WORD_BITS + b;
          if (pnum >= page_total) return 1'b0;
          if (!page_map[w][b]) begin
            found = pnum;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one word to the shadow state and work out its result
  function automatic page_result_t predict_page_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [PAGE_W-1:0] pg);
    page_result_t res;
    int unsigned  pnum;
    int unsigned  slot;
    pnum = pg;
    res.page_nr = pg;
    res.st = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        if (lowest_free_page(slot)) begin
          page_map[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
          pages_in_use++;
          res.page_nr = slot[PAGE_W-1:0];
        end else begin
          res.page_nr = '0;
          res.st = ST_OOM;
        end
      end
      CMD_FREE: begin
        if (pnum == 0) res.st = ST_NULL;
        else if (pnum >= page_total) res.st = ST_INVALID;
        else if (!page_is_used(pnum)) res.st = ST_DOUBLE;
        else begin
          page_map[pnum / WORD_BITS][pnum % WORD_BITS] = 1'b0;
          if (pages_in_use > 0) pages_in_use--;
        end
      end
      CMD_RESERVE: begin
        if (pnum >= page_total) res.st = ST_INVALID;
        else if (!page_is_used(pnum)) begin
          page_map[pnum / WORD_BITS][pnum % WORD_BITS] = 1'b1;
          pages_in_use++;
        end
      end
      default: res.st = ST_INVALID;
    endcase
    res.free_cnt = (pages_in_use <= page_total) ? CFG_W'(page_total - pages_in_use) : '0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %0s at result %0d: got 0x%0h, expected 0x%0h",
             $realtime, what, result_index, got, want);
    fail_count++;
  endtask

  // watch the register port and both channels
  always @(posedge clk) begin
    logic [CFG_W-1:0] new_total;
    page_result_t     head;
    if (rst) begin
      page_total = MAX_PAGES;
      mark_every_page_used();
      awaited_results.delete();
      result_index = 0;
      fail_count = 0;
    end else begin
      // register write: saturate, then every page used
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_TOTAL_PAGES) begin
        new_total = pwdata[CFG_W-1:0];
        if (new_total > MAX_PAGES) new_total = MAX_PAGES;
        page_total = new_total;
        mark_every_page_used();
      end
      // register read-back
      if (psel && penable && !pwrite && pready && paddr[APB_AW-1:2] == REG_TOTAL_PAGES) begin
        if (prdata !== APB_DW'(page_total)) report_mismatch("prdata", prdata, page_total);
      end
      // accepted input word
      if (in_valid && in_ready) awaited_results.push_back(predict_page_result(command, page));
      // accepted result word
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          // result word with nothing awaited
          report_mismatch("unexpected result page_out", 32'(page_out), 32'd0);
        end else begin
          head = awaited_results.pop_front();
          if (page_out !== head.page_nr) report_mismatch("page_out", page_out, head.page_nr);
          if (status !== head.st) report_mismatch("status", status, head.st);
          if (free_pages !== head.free_cnt)
            report_mismatch("free_pages", free_pages, head.free_cnt);
        end
        result_index++;
      end
    end
    pending <= awaited_results.size();
  end

endmodule

/* tb/bitmap_page_allocator_unit_tb.sv */
// Testbench top for the page allocator: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int unsigned CYCLE_LIMIT   = 15_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          NUM_PHASES    = 14;

  localparam logic [CMD_W-1:0]  CMD_UNUSED       = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_TOTAL_PAGES = {REG_TOTAL_PAGES, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED    = {~REG_TOTAL_PAGES, 2'b00};

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [PAGE_W-1:0]   page;
  logic                out_valid;
  logic                out_ready;
  logic [PAGE_W-1:0]   page_out;
  logic [STATUS_W-1:0] status;
  logic [CFG_W-1:0]    free_pages;

  int          pending;
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_requests;
  int          holds_served = 0;
  int unsigned cycle_count = 0;

  int unsigned phase_totals [NUM_PHASES] = '{37, 1, 64, 65536, 200, 33, 300, 65535, 0, 120,
                                             31, 2048, 90, 250};

  always #(CLK_PERIOD / 2) clk = ~clk;

  bitmap_page_allocator_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .page(page),
    .out_valid(out_valid), .out_ready(out_ready), .page_out(page_out), .status(status),
    .free_pages(free_pages)
  );

  bitmap_page_allocator_checker result_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .page(page),
    .out_valid(out_valid), .out_ready(out_ready), .page_out(page_out), .status(status),
    .free_pages(free_pages),
    .pending(pending), .fail_count(fail_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // APB write: setup then access
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // APB read; the checker compares prdata
  task automatic apb_read(input logic [APB_AW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // offer one word; valid stays high into the next word when there is no gap
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    page     <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new page total, then read it back
  task automatic set_total(input logic [APB_DW-1:0] data);
    wait_drained();
    apb_write(ADDR_TOTAL_PAGES, data);
    apb_read(ADDR_TOTAL_PAGES);
  endtask

  initial begin : stimulus
    int unsigned      total;
    int               pick;
    int               count;
    logic [CMD_W-1:0] cmd;
    logic [PAGE_W-1:0] pg;

    hold_requests  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    command  <= '0;
    page     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset total, every page used
    send_word(CMD_ALLOC, 16'h1234);     // out of memory
    send_word(CMD_FREE, 16'h0000);      // null address ignored
    send_word(CMD_FREE, 16'hFFFF);
    send_word(CMD_FREE, 16'hFFFF);      // double free
    send_word(CMD_ALLOC, 16'h0000);     // gets the top page
    send_word(CMD_RESERVE, 16'hFFFF);   // already used
    send_word(CMD_FREE, 16'h5555);
    send_word(CMD_FREE, 16'hAAAA);
    send_word(CMD_FREE, 16'h0001);
    send_word(CMD_ALLOC, 16'hFFFF);     // lowest free page wins
    send_word(CMD_RESERVE, 16'h5555);   // free page taken by reserve
    send_word(CMD_RESERVE, 16'h0000);   // page zero like any other
    send_word(CMD_UNUSED, 16'hFFFF);    // unused command

    // write to a register that does not exist, total must stay
    wait_drained();
    apb_write(ADDR_UNMAPPED, 32'h0000_0005);
    apb_read(ADDR_TOTAL_PAGES);

    // above the maximum: saturates
    set_total(32'hFFFF_FFFF);
    send_word(CMD_FREE, 16'h0007);
    send_word(CMD_ALLOC, 16'h0000);

    // tiny total: edges of the range
    set_total(32'h0000_0005);
    send_word(CMD_FREE, 16'h0005);      // beyond total
    send_word(CMD_RESERVE, 16'h0005);   // beyond total
    send_word(CMD_FREE, 16'h0004);
    send_word(CMD_FREE, 16'h0003);
    send_word(CMD_FREE, 16'h0003);
    send_word(CMD_ALLOC, 16'h0000);
    send_word(CMD_ALLOC, 16'h0000);

    // no pages at all
    set_total(32'h0000_0000);
    send_word(CMD_ALLOC, 16'h0000);
    send_word(CMD_RESERVE, 16'h0000);

    // random phases over several totals and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      total = phase_totals[p];
      set_total({15'($urandom()), 17'(total)});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      count = (total >= 2048) ? 80 : 140;
      for (int n = 0; n < count; n++) begin
        // long receiver hold-off while words keep coming
        if (p == 0 && n == 20) hold_requests++;
        // sender pause until everything is back
        if (p == 6 && n == 70) wait_drained();
        pick = $urandom_range(99);
        if (pick < 38) cmd = CMD_ALLOC;
        else if (pick < 72) cmd = CMD_FREE;
        else if (pick < 96) cmd = CMD_RESERVE;
        else cmd = CMD_UNUSED;
        pick = $urandom_range(99);
        if (total == 0 || pick < 12) pg = 16'($urandom());
        else if (pick < 24) begin
          case ($urandom_range(3))
            0: pg = '0;
            1: pg = 16'd1;
            2: pg = 16'(total - 1);
            default: pg = 16'(total);
          endcase
        end else pg = 16'($urandom_range(total - 1));
        send_word(cmd, pg);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* bitmap_page_allocator_unit.f */
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_cfg.sv
rtl/core/bitmap_page_allocator_unit.sv
tb/bitmap_page_allocator_checker.sv
tb/bitmap_page_allocator_unit_tb.sv
